@@ rtl/ffha_pkg.sv @@
package ffha_pkg;

	// Heap geometry
	localparam int HEAP_BYTES = 64;
	localparam int IDX_W      = $clog2(HEAP_BYTES);
	localparam int HDR_BYTES  = 4;

	// Operation codes
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_INC   = 2'd2;
	localparam logic [1:0] OP_DEC   = 2'd3;

	// Status codes
	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_NOFIT    = 2'd1;
	localparam logic [1:0] ST_IGNORED  = 2'd2;
	localparam logic [1:0] ST_RELEASED = 2'd3;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] request_size;
		logic [5:0] payload_offset;
		logic       handle_valid;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] granted_offset;
		logic [7:0] ref_after;
	} rsp_t;

	// Block header, 25 bits: refs [24:17], next [16:9], free [8], size [7:0]
	typedef struct packed {
		logic [7:0] refs;
		logic [7:0] next;
		logic       free;
		logic [7:0] size;
	} hdr_t;

	localparam hdr_t HDR_INIT = '{
		refs: 8'd0,
		next: 8'd0,
		free: 1'b1,
		size: 8'(HEAP_BYTES - HDR_BYTES)
	};

endpackage

@@ rtl/ffha_ram.sv @@
module ffha_ram #(
	parameter int WIDTH = 25,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/first_fit_heap_allocator_core.sv @@
// First-fit heap allocator over a small byte heap, with reference counts
// and forward coalescing. Block headers live in a single-port-write,
// registered-read header RAM, one entry per byte offset.
// cmd channel (valid/ready): one item per operation (allocate, free,
// increment, decrement). rsp channel (valid/ready): exactly one item per
// command, in order. cmd_ready is high only while the sequencer is idle.
//
// Steps per command, from the cmd accept to the rsp register:
//   ignored command            : straight to the push state
//   free / increment / decrement: update the header, plus a merge reading the next one
//   allocate                   : walk the header chain (1 per cycle, up to
//                                HEAP_BYTES), plus a head write when the block is split
// The next command is taken in the cycle after the response is loaded; the
// chain walk through the header RAM sets how long an allocate takes.
// Reset clears the per-entry fill bits, so every header reads as its reset
// value (entry 0 one free block covering the heap, all others zero) until it
// is first written; no clearing pass is needed. When the receiver stalls, the
// finished item waits in the rsp register and the sequencer holds its next
// result until that register frees up; no command is taken meanwhile.
module first_fit_heap_allocator_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  ffha_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ffha_pkg::rsp_t rsp
);

	localparam int IDX_W = ffha_pkg::IDX_W;
	localparam int SPL_W = 10;  // cur + header + request, max 63+4+255

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a command
	localparam logic [2:0] S_AEV  = 3'd1;  // allocate: check one header per cycle
	localparam logic [2:0] S_AFIN = 3'd2;  // allocate: write the granted header after a split
	localparam logic [2:0] S_HEV  = 3'd3;  // free/ref: update the addressed header
	localparam logic [2:0] S_MEV  = 3'd4;  // release: merge with a free successor
	localparam logic [2:0] S_PUSH = 3'd5;  // hand the result to the rsp register

	logic [2:0]            state_q, state_d;
	logic [1:0]            op_q;
	logic [7:0]            req_q;
	logic [IDX_W-1:0]      cur_q, cur_d;     // header being looked at / written
	logic [IDX_W-1:0]      steps_q, steps_d; // headers walked so far
	ffha_pkg::hdr_t        hold_q, hold_d;   // header waiting to be written
	ffha_pkg::rsp_t        res_q, res_d;
	ffha_pkg::rsp_t        rsp_q;
	logic                  rsp_valid_q;
	logic [ffha_pkg::HEAP_BYTES-1:0] hvld_q; // entry written since reset
	logic                  rd_fill_q;
	logic [IDX_W-1:0]      rd_addr_q;

	// Header RAM port signals
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	ffha_pkg::hdr_t        ram_wdata;
	logic [IDX_W-1:0]      ram_raddr;
	ffha_pkg::hdr_t        ram_rdata;
	ffha_pkg::hdr_t        hdr;              // header as seen through the fill bits

	// Decode of the incoming command
	logic [5:0]            cmd_idx;
	logic                  cmd_ign;

	// Allocate datapath
	logic                  a_fit;
	logic [7:0]            a_rest;
	logic [SPL_W-1:0]      a_split_at;
	logic                  a_split;
	logic                  a_next_ok;
	logic [SPL_W-1:0]      a_grant;

	// Release path
	logic                  rel;
	ffha_pkg::hdr_t        rel_hdr;
	ffha_pkg::hdr_t        rel_free;
	logic                  rel_merge;
	ffha_pkg::hdr_t        upd_hdr;

	logic                  push_go;

	ffha_ram #(
		.WIDTH($bits(ffha_pkg::hdr_t)),
		.DEPTH(ffha_pkg::HEAP_BYTES)
	) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Unwritten entries read as their reset value
	assign hdr = rd_fill_q ? ram_rdata :
		((rd_addr_q == '0) ? ffha_pkg::HDR_INIT : '0);

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign push_go   = (state_q == S_PUSH) && (!rsp_valid_q || rsp_ready);

	// Command decode: header sits 4 bytes before the payload
	assign cmd_idx = cmd.payload_offset - 6'(ffha_pkg::HDR_BYTES);
	assign cmd_ign = !cmd.handle_valid
		|| (cmd.payload_offset < 6'(ffha_pkg::HDR_BYTES))
		|| (int'(cmd_idx) >= ffha_pkg::HEAP_BYTES);

	// First-fit test and split arithmetic on the current header
	assign a_fit      = hdr.free && (hdr.size >= req_q);
	assign a_rest     = hdr.size - req_q;
	assign a_split_at = SPL_W'(cur_q) + SPL_W'(ffha_pkg::HDR_BYTES) + SPL_W'(req_q);
	assign a_split    = (a_rest > 8'(ffha_pkg::HDR_BYTES))
		&& (int'(a_split_at) < ffha_pkg::HEAP_BYTES);
	assign a_next_ok  = (hdr.next != '0) && (int'(hdr.next) < ffha_pkg::HEAP_BYTES);
	assign a_grant    = SPL_W'(cur_q) + SPL_W'(ffha_pkg::HDR_BYTES);

	// Release: mark free, and look at the successor when the link is in range
	always_comb begin
		rel_free      = rel_hdr;
		rel_free.free = 1'b1;
	end
	assign rel_merge = (rel_hdr.next != '0) && (int'(rel_hdr.next) < ffha_pkg::HEAP_BYTES);

	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		steps_d   = steps_q;
		hold_d    = hold_q;
		res_d     = res_q;
		ram_raddr = cur_q;
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = hold_q;
		rel       = 1'b0;
		rel_hdr   = hdr;
		upd_hdr   = hdr;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					if (cmd.operation == ffha_pkg::OP_ALLOC) begin
						cur_d     = '0;
						steps_d   = '0;
						ram_raddr = '0;
						state_d   = S_AEV;
					end else if (cmd_ign) begin
						res_d   = '{status: ffha_pkg::ST_IGNORED,
							granted_offset: 6'd0, ref_after: 8'd0};
						state_d = S_PUSH;
					end else begin
						cur_d     = IDX_W'(cmd_idx);
						ram_raddr = IDX_W'(cmd_idx);
						state_d   = S_HEV;
					end
				end
			end

			S_AEV: begin
				if (a_fit) begin
					res_d = '{status: ffha_pkg::ST_DONE,
						granted_offset: 6'(a_grant), ref_after: 8'd1};
					if (a_split) begin
						// tail becomes a new free block, head written next cycle
						ram_we    = 1'b1;
						ram_waddr = a_split_at[IDX_W-1:0];
						ram_wdata = '{refs: 8'd0, next: hdr.next, free: 1'b1,
							size: a_rest - 8'(ffha_pkg::HDR_BYTES)};
						hold_d    = '{refs: 8'd1, next: 8'(a_split_at), free: 1'b0,
							size: req_q};
						state_d   = S_AFIN;
					end else begin
						ram_we    = 1'b1;
						ram_wdata = '{refs: 8'd1, next: hdr.next, free: 1'b0,
							size: hdr.size};
						state_d   = S_PUSH;
					end
				end else if (!a_next_ok || steps_q == IDX_W'(ffha_pkg::HEAP_BYTES - 1)) begin
					// end of chain, broken link or walk limit
					res_d   = '{status: ffha_pkg::ST_NOFIT,
						granted_offset: 6'd0, ref_after: 8'd0};
					state_d = S_PUSH;
				end else begin
					cur_d     = hdr.next[IDX_W-1:0];
					steps_d   = steps_q + IDX_W'(1);
					ram_raddr = hdr.next[IDX_W-1:0];
				end
			end

			S_AFIN: begin
				ram_we  = 1'b1;
				state_d = S_PUSH;
			end

			S_HEV: begin
				state_d = S_PUSH;
				case (op_q)
					ffha_pkg::OP_FREE: begin
						if (hdr.free) begin
							res_d = '{status: ffha_pkg::ST_DONE,
								granted_offset: 6'd0, ref_after: hdr.refs};
						end else begin
							rel = 1'b1;
						end
					end
					ffha_pkg::OP_INC: begin
						if (hdr.refs != 8'hFF) begin
							upd_hdr.refs = hdr.refs + 8'd1;
						end
						ram_we    = 1'b1;
						ram_wdata = upd_hdr;
						res_d     = '{status: ffha_pkg::ST_DONE,
							granted_offset: 6'd0, ref_after: upd_hdr.refs};
					end
					ffha_pkg::OP_DEC: begin
						upd_hdr.refs = hdr.refs - 8'd1;
						if (hdr.refs == 8'd0) begin
							res_d = '{status: ffha_pkg::ST_DONE,
								granted_offset: 6'd0, ref_after: 8'd0};
						end else if (upd_hdr.refs == 8'd0 && !hdr.free) begin
							rel     = 1'b1;
							rel_hdr = upd_hdr;
						end else begin
							ram_we    = 1'b1;
							ram_wdata = upd_hdr;
							res_d     = '{status: ffha_pkg::ST_DONE,
								granted_offset: 6'd0, ref_after: upd_hdr.refs};
						end
					end
					default: begin
						res_d = '{status: ffha_pkg::ST_IGNORED,
							granted_offset: 6'd0, ref_after: 8'd0};
					end
				endcase

				if (rel) begin
					res_d  = '{status: ffha_pkg::ST_RELEASED,
						granted_offset: 6'd0, ref_after: rel_hdr.refs};
					hold_d = rel_free;
					if (rel_merge) begin
						ram_raddr = rel_hdr.next[IDX_W-1:0];
						state_d   = S_MEV;
					end else begin
						ram_we    = 1'b1;
						ram_wdata = rel_free;
					end
				end
			end

			S_MEV: begin
				// hdr is the successor; absorb it if free, size wraps in 8 bits
				ram_we    = 1'b1;
				ram_wdata = hold_q;
				if (hdr.free) begin
					ram_wdata.size = hold_q.size + 8'(ffha_pkg::HDR_BYTES) + hdr.size;
					ram_wdata.next = hdr.next;
				end
				state_d = S_PUSH;
			end

			S_PUSH: begin
				if (push_go) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			hvld_q      <= '0;
			rd_fill_q   <= 1'b0;
			rd_addr_q   <= '0;
			steps_q     <= '0;
			cur_q       <= '0;
		end else begin
			state_q   <= state_d;
			cur_q     <= cur_d;
			steps_q   <= steps_d;
			rd_addr_q <= ram_raddr;
			rd_fill_q <= hvld_q[ram_raddr];
			if (ram_we) begin
				hvld_q[ram_waddr] <= 1'b1;
			end
			if (push_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		hold_q <= hold_d;
		res_q  <= res_d;
		if (cmd_valid && cmd_ready) begin
			op_q  <= cmd.operation;
			req_q <= cmd.request_size;
		end
		if (push_go) begin
			rsp_q <= res_q;
		end
	end

`ifndef NO_ASSERTIONS
	// Header RAM is only written while an operation is in flight
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q != S_IDLE && state_q != S_PUSH))
		else $error("header write outside an operation");

	// One command at a time: an accept closes the input for the next cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("command accepted while busy");

	// A stalled rsp register keeps the sequencer waiting in its push state
	a_push_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH && rsp_valid_q && !rsp_ready) |=> state_q == S_PUSH)
		else $error("result dropped under back-pressure");

	// Only a successful allocate returns an offset
	a_grant_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.granted_offset != 6'd0) |-> rsp_q.status == ffha_pkg::ST_DONE)
		else $error("granted offset with non-done status");
`endif

endmodule
